/* sv/mpd_pkg.sv */
// ----------------------------------------------------------------------------
// mpd_pkg - shared types and constants for the Merkle path direction block
// Field widths, depth limit and the step unit's result bundle.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int SIZE_W         = 32;
  localparam int LEVEL_W        = 6;
  localparam int MAX_TREE_DEPTH = 32;

  // result of one pass through the shared compare/subtract unit
  typedef struct packed {
    logic              search;    // mask not yet below size
    logic              right;     // index bit under mask is set
    logic [SIZE_W-1:0] size_sub;  // size - mask
    logic [SIZE_W-1:0] index_sub; // index - mask
  } step_res_t;

endpackage

/* sv/merkle_path_direction_top.sv */
// ----------------------------------------------------------------------------
// merkle_path_direction_top - path direction of a leaf in an unbalanced tree
// Reports whether a leaf's path goes left (0) or right (1) at a given level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries tree_size, leaf_index and
//   level. Result channel (out_valid/out_ready) carries direction and
//   valid_res; valid_res is 0 for a size below two, an index not below the
//   size, or a level past the end of the path (direction is then 0).
//   One item is in flight at a time: in_ready is high only while idle.
//   After the transfer in, the operands are checked in ST_CHECK, then the walk
//   in ST_RUN takes one mask position per cycle: the mask starts at bit 31 and
//   moves down one bit at a time, either while searching for the first power
//   of two below the size or while applying one tree level. When the path
//   ends above the requested level, a final pass through ST_RUN ends the walk.
//   The result is then offered in ST_OUT, and in_ready returns in the cycle
//   after the result transfer.
//   The result is held in an output register until out_ready; a stalled
//   receiver simply holds the block busy. Synchronous active-low reset
//   returns the block to idle with no result pending.
// ----------------------------------------------------------------------------
module merkle_path_direction_top
  import mpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SIZE_W-1:0]  in_tree_size,
  input  logic [SIZE_W-1:0]  in_leaf_index,
  input  logic [LEVEL_W-1:0] in_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_direction,
  output logic               out_valid_res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  localparam logic [SIZE_W-1:0]  MASK_TOP  = {1'b1, {(SIZE_W-1){1'b0}}};
  localparam logic [SIZE_W-1:0]  SIZE_ONE  = SIZE_W'(1);
  localparam logic [LEVEL_W-1:0] DEPTH_LIM = LEVEL_W'(MAX_TREE_DEPTH);

  logic [1:0]         state_r, state_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [SIZE_W-1:0]  index_r, index_nxt;
  logic [SIZE_W-1:0]  mask_r, mask_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [LEVEL_W-1:0] step_r, step_nxt;
  logic               dir_r, dir_nxt;
  logic               ok_r, ok_nxt;
  step_res_t          su;

  mpd_step_unit u_step (
    .size  (size_r),
    .index (index_r),
    .mask  (mask_r),
    .res   (su)
  );

  always_comb begin
    state_nxt = state_r;
    size_nxt  = size_r;
    index_nxt = index_r;
    mask_nxt  = mask_r;
    level_nxt = level_r;
    step_nxt  = step_r;
    dir_nxt   = dir_r;
    ok_nxt    = ok_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          size_nxt  = in_tree_size;
          index_nxt = in_leaf_index;
          level_nxt = in_level;
          mask_nxt  = MASK_TOP;
          step_nxt  = '0;
          dir_nxt   = 1'b0;
          ok_nxt    = 1'b0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (size_r <= SIZE_ONE || index_r >= size_r || level_r >= DEPTH_LIM) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (size_r == SIZE_ONE) begin
          // path ended above the requested level
          state_nxt = ST_OUT;
        end else if (su.search) begin
          mask_nxt = mask_r >> 1;
        end else if (step_r == level_r) begin
          dir_nxt   = su.right;
          ok_nxt    = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          // new size never exceeds the mask, so the search resumes from half the mask
          if (su.right) begin
            size_nxt  = su.size_sub;
            index_nxt = su.index_sub;
          end else begin
            size_nxt  = mask_r;
          end
          mask_nxt = mask_r >> 1;
          step_nxt = step_r + LEVEL_W'(1);
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    index_r <= index_nxt;
    mask_r  <= mask_nxt;
    level_r <= level_nxt;
    step_r  <= step_nxt;
    dir_r   <= dir_nxt;
    ok_r    <= ok_nxt;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = (state_r == ST_OUT);
  assign out_direction = dir_r;
  assign out_valid_res = ok_r;

  // a transfer in always starts the operand check
  a_start_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_CHECK))
    else $error("transfer in did not start operand check");

  // the walk keeps the leaf inside the remaining subtree
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (index_r < size_r))
    else $error("leaf index left the subtree");

  // mask is still nonzero whenever a level can be applied
  a_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && size_r > SIZE_ONE) |-> (mask_r != '0))
    else $error("mask ran out before the path ended");

  // a left direction is reported for every invalid result
  a_invalid_left: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> !out_direction)
    else $error("invalid result carries a right direction");

endmodule

/* sv/mpd_step_unit.sv */
// ----------------------------------------------------------------------------
// mpd_step_unit - compare and subtract unit shared by every tree level
// Tests the mask against the remaining size, picks the index bit under it
// and forms the right-branch size and index.
// ----------------------------------------------------------------------------
module mpd_step_unit
  import mpd_pkg::*;
(
  input  logic [SIZE_W-1:0] size,
  input  logic [SIZE_W-1:0] index,
  input  logic [SIZE_W-1:0] mask,
  output step_res_t         res
);

  always_comb begin
    res.search    = (mask >= size);
    res.right     = |(index & mask);
    res.size_sub  = size - mask;
    res.index_sub = index - mask;
  end

endmodule

/* tb/merkle_path_direction_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// merkle_path_direction_top_tb - self-checking bench for the path direction block
// Sends tree size / leaf index / level queries, predicts the left/right step
// and valid flag per query, and checks every result transfer in order with
// the sender idling and the receiver stalling at rates set per test phase.
// ----------------------------------------------------------------------------
module merkle_path_direction_top_tb;
  import mpd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 340;

  typedef struct packed {
    logic direction;
    logic valid_res;
  } path_step_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [SIZE_W-1:0]  in_tree_size;
  logic [SIZE_W-1:0]  in_leaf_index;
  logic [LEVEL_W-1:0] in_level;
  logic               out_valid;
  logic               out_ready;
  logic               out_direction;
  logic               out_valid_res;

  path_step_t pending_steps[$];
  int         error_count;
  int         cycle_count;
  int         idle_pct;
  int         stall_pct;

  merkle_path_direction_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_tree_size  (in_tree_size),
    .in_leaf_index (in_leaf_index),
    .in_level      (in_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_direction (out_direction),
    .out_valid_res (out_valid_res)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // walk from the root: the left subtree takes the largest power of two
  // strictly below the current leaf count
  function automatic path_step_t path_direction(input logic [SIZE_W-1:0] tree_size,
                                                input logic [SIZE_W-1:0] leaf_index,
                                                input logic [LEVEL_W-1:0] level);
    logic [SIZE_W:0] count;
    logic [SIZE_W:0] idx;
    logic [SIZE_W:0] half;
    logic            goes_right;
    logic            found;
    int              depth;
    path_step_t      res;
    res   = '0;
    found = 1'b0;
    count = {1'b0, tree_size};
    idx   = {1'b0, leaf_index};
    if (count > 1 && idx < count) begin
      for (depth = 0; depth < MAX_TREE_DEPTH && count > 1 && !found; depth++) begin
        half = (SIZE_W+1)'(1);
        while ((half << 1) < count) half = half << 1;
        goes_right = (idx & half) != 0;
        if (depth == int'(level)) begin
          res.direction = goes_right;
          res.valid_res = 1'b1;
          found         = 1'b1;
        end else if (goes_right) begin
          count = count - half;
          idx   = idx - half;
        end else begin
          count = half;
        end
      end
    end
    return res;
  endfunction

  task automatic send_query(input logic [SIZE_W-1:0] tree_size,
                            input logic [SIZE_W-1:0] leaf_index,
                            input logic [LEVEL_W-1:0] level);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_tree_size  <= tree_size;
    in_leaf_index <= leaf_index;
    in_level      <= level;
    do @(posedge clk); while (!in_ready);
    pending_steps.push_back(path_direction(tree_size, leaf_index, level));
  endtask

  task automatic set_idling(input int sender_idle, input int receiver_stall);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
  endtask

  task automatic test_degenerate_sizes();
    send_query(32'd0, 32'd0, 6'd0);
    send_query(32'd1, 32'd0, 6'd0);
    send_query(32'd0, 32'hFFFF_FFFF, 6'd63);
    send_query(32'd2, 32'd0, 6'd0);
    send_query(32'd2, 32'd1, 6'd0);
    send_query(32'd3, 32'd2, 6'd0);
  endtask

  task automatic test_index_bounds();
    send_query(32'd5, 32'd5, 6'd0);
    send_query(32'd5, 32'hFFFF_FFFF, 6'd0);
    send_query(32'd5, 32'd4, 6'd0);
    send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
    send_query(32'hFFFF_FFFF, 32'hFFFF_FFFE, 6'd0);
  endtask

  task automatic test_level_bounds();
    send_query(32'd2, 32'd1, 6'd1);         // right leaf reached after one step
    send_query(32'd3, 32'd2, 6'd1);
    send_query(32'd3, 32'd1, 6'd1);
    send_query(32'h8000_0001, 32'h8000_0000, 6'd0);
    send_query(32'h8000_0001, 32'h8000_0000, 6'd1);
    send_query(32'hFFFF_FFFF, 32'd0, 6'd31);  // deepest leaf: 32 steps
    send_query(32'hFFFF_FFFF, 32'd0, 6'd32);  // past the depth limit
    send_query(32'hFFFF_FFFF, 32'h7FFF_FFFF, 6'd63);
  endtask

  task automatic test_full_width();
    send_query(32'h8000_0000, 32'h7FFF_FFFF, 6'd30);
    send_query(32'h8000_0000, 32'h5555_5555, 6'd31);
    send_query(32'hFFFF_FFFF, 32'hAAAA_AAAA, 6'd5);
    send_query(32'hFFFF_FFFF, 32'hFFFF_FFFD, 6'd30);
  endtask

  task automatic send_random_query();
    logic [63:0]        span;
    logic [SIZE_W-1:0]  tree_size;
    logic [SIZE_W-1:0]  leaf_index;
    logic [LEVEL_W-1:0] level;
    int                 bits;
    int                 pick;
    bits      = $urandom_range(1, SIZE_W);
    span      = (64'd1 << bits) - 1;
    tree_size = $urandom & span[SIZE_W-1:0];
    pick      = $urandom_range(99);
    if (pick < 4) begin
      tree_size  = $urandom_range(1);
      leaf_index = $urandom;
      level      = LEVEL_W'($urandom);
    end else begin
      if (tree_size < 2) tree_size = 2;
      pick = $urandom_range(99);
      if (pick < 85) leaf_index = $urandom % tree_size;
      else if (pick < 95) begin
        span       = (64'd1 << SIZE_W) - 64'(tree_size);
        leaf_index = tree_size + SIZE_W'(64'($urandom) % span);
      end
      else leaf_index = $urandom;
      // most levels inside the path, some past it, some fully random
      pick = $urandom_range(99);
      if (pick < 85) level = LEVEL_W'($urandom_range(0, $clog2(tree_size)));
      else if (pick < 93) level = LEVEL_W'($urandom_range($clog2(tree_size), 33));
      else level = LEVEL_W'($urandom);
    end
    send_query(tree_size, leaf_index, level);
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(72, 0);
        2:       set_idling(0, 72);
        default: set_idling(29, 29);
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) send_random_query();
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    path_step_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_steps.size() == 0) begin
        $display("%0t: unexpected result: direction %0b valid_res %0b", $time,
                 out_direction, out_valid_res);
        error_count++;
      end else begin
        want = pending_steps.pop_front();
        if (out_direction !== want.direction) begin
          $display("%0t: direction mismatch: expected %0b actual %0b", $time,
                   want.direction, out_direction);
          error_count++;
        end
        if (out_valid_res !== want.valid_res) begin
          $display("%0t: valid_res mismatch: expected %0b actual %0b", $time,
                   want.valid_res, out_valid_res);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    error_count   = 0;
    cycle_count   = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_tree_size  <= '0;
    in_leaf_index <= '0;
    in_level      <= '0;
    out_ready     <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0, 0);
    test_degenerate_sizes();
    set_idling(29, 29);
    test_index_bounds();
    set_idling(0, 72);
    test_level_bounds();
    set_idling(72, 0);
    test_full_width();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mpd_pkg.sv
sv/mpd_step_unit.sv
sv/merkle_path_direction_top.sv
tb/merkle_path_direction_top_tb.sv
